/* rtl/ufd_pkg.sv */
// Types, constants and the byte-wide CRC-16 CCITT update for the frame deframer.
// No dependencies.
package ufd_pkg;

    localparam logic [7:0]  HDR_FIRST      = 8'hAA;
    localparam logic [7:0]  HDR_SECOND     = 8'h55;
    localparam logic [7:0]  VERSION_MAX    = 8'h01;
    localparam logic [8:0]  HDR_BYTES      = 9'd5;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_INIT       = 16'h0000;
    localparam logic [7:0]  MAX_LEN_RESET  = 8'd64;

    localparam logic [8:0]  POS_HDR_FIRST  = 9'd0;
    localparam logic [8:0]  POS_HDR_SECOND = 9'd1;
    localparam logic [8:0]  POS_VERSION    = 9'd2;
    localparam logic [8:0]  POS_COMMAND    = 9'd3;
    localparam logic [8:0]  POS_LENGTH     = 9'd4;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // One classified transaction from front to back.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [7:0]  index;
        logic        version;
        logic [7:0]  command;
        logic [7:0]  length;
        logic        fits;
        logic [15:0] crc_calc;
        logic [15:0] crc_rcvd;
    } t_ufd_rec;

    typedef struct packed {
        logic     push;
        t_ufd_rec rec;
    } t_ufd_push;

    typedef struct packed {
        logic     avail;
        t_ufd_rec rec;
    } t_ufd_head;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/ufd_in_if.sv */
// Input byte channel: valid/ready handshake with one received byte.
// No dependencies.
interface ufd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/ufd_out_if.sv */
// Result channel: valid/ready handshake with one payload or frame-end result.
// No dependencies.
interface ufd_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_version;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic       crc_checked;
    logic       crc_ok;

    modport source (
        output valid, output result_kind, output payload_byte, output payload_index,
        output frame_version, output frame_command, output frame_length,
        output crc_checked, output crc_ok, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input payload_index,
        input frame_version, input frame_command, input frame_length,
        input crc_checked, input crc_ok, output ready
    );
endinterface

/* rtl/ufd_front.sv */
// Front end: accepts bytes, tracks frame position and header, runs the CRC
// and pushes classified transactions. Depends on ufd_pkg and ufd_in_if.
module ufd_front #(
    parameter int CRC_SPAN = 38
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    ufd_in_if.sink               i_rx,
    input  logic                 i_full,
    output ufd_pkg::t_ufd_push   o_push
);

    localparam logic [8:0] SPAN     = 9'(CRC_SPAN);
    localparam logic [8:0] SPAN_LO  = 9'(CRC_SPAN + 1);
    localparam logic [8:0] FIT_END  = 9'(CRC_SPAN + 2);

    logic [7:0]  r_max_len;
    logic [8:0]  r_pos,  n_pos;
    logic        r_ver,  n_ver;
    logic [7:0]  r_cmd,  n_cmd;
    logic [7:0]  r_len,  n_len;
    logic [15:0] r_crc,  n_crc;
    logic [15:0] r_rcrc, n_rcrc;

    logic        fire;
    logic        take;
    logic        hunt;
    logic [7:0]  b;
    logic [8:0]  frame_end;

    assign i_rx.ready = !i_full;
    assign fire       = i_rx.valid && !i_full;
    assign b          = i_rx.rx_byte;
    assign frame_end  = {1'b0, r_len} + ufd_pkg::HDR_BYTES;

    always_comb begin
        n_pos  = r_pos;
        n_ver  = r_ver;
        n_cmd  = r_cmd;
        n_len  = r_len;
        n_crc  = r_crc;
        n_rcrc = r_rcrc;
        take   = 1'b0;
        hunt   = 1'b0;
        o_push = '0;
        o_push.rec.version = r_ver;
        o_push.rec.command = r_cmd;
        o_push.rec.length  = r_len;
        o_push.rec.fits    = (FIT_END <= frame_end);
        o_push.rec.crc_calc = r_crc;
        o_push.rec.crc_rcvd = r_rcrc;

        if (fire) begin
            priority if (r_pos == ufd_pkg::POS_HDR_FIRST) begin
                take = (b == ufd_pkg::HDR_FIRST);
            end else if (r_pos == ufd_pkg::POS_HDR_SECOND) begin
                take = (b == ufd_pkg::HDR_SECOND);
                hunt = !take;
            end else if (r_pos == ufd_pkg::POS_VERSION) begin
                take = (b <= ufd_pkg::VERSION_MAX);
                hunt = !take;
                if (take) begin
                    n_ver = b[0];
                end
            end else if (r_pos == ufd_pkg::POS_COMMAND) begin
                n_cmd = b;
                take  = 1'b1;
            end else if (r_pos == ufd_pkg::POS_LENGTH) begin
                n_len = b;
                take  = (b <= r_max_len);
                hunt  = !take;
            end else if (r_pos < frame_end) begin
                take            = 1'b1;
                o_push.push     = 1'b1;
                o_push.rec.kind = ufd_pkg::KIND_PAYLOAD;
                o_push.rec.data = b;
                o_push.rec.index = 8'(r_pos - ufd_pkg::HDR_BYTES);
            end else begin
                hunt            = 1'b1;
                o_push.push     = 1'b1;
                o_push.rec.kind = ufd_pkg::KIND_FRAME_END;
            end

            if (take) begin
                priority if (r_pos < SPAN) begin
                    n_crc = ufd_pkg::crc_feed(r_crc, b);
                end else if (r_pos == SPAN) begin
                    n_rcrc[15:8] = b;
                end else if (r_pos == SPAN_LO) begin
                    n_rcrc[7:0] = b;
                end else begin
                    n_rcrc = r_rcrc;
                end
                n_pos = r_pos + 9'd1;
            end
            if (hunt) begin
                n_pos  = ufd_pkg::POS_HDR_FIRST;
                n_crc  = ufd_pkg::CRC_INIT;
                n_rcrc = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= ufd_pkg::MAX_LEN_RESET;
            r_pos     <= ufd_pkg::POS_HDR_FIRST;
            r_ver     <= 1'b0;
            r_cmd     <= '0;
            r_len     <= '0;
            r_crc     <= ufd_pkg::CRC_INIT;
            r_rcrc    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            r_pos  <= n_pos;
            r_ver  <= n_ver;
            r_cmd  <= n_cmd;
            r_len  <= n_len;
            r_crc  <= n_crc;
            r_rcrc <= n_rcrc;
        end
    end

endmodule

/* rtl/ufd_fifo.sv */
// Two-entry queue of classified transactions between front and back.
// Depends on ufd_pkg.
module ufd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ufd_pkg::t_ufd_push i_push,
    input  logic               i_pop,
    output logic               o_full,
    output ufd_pkg::t_ufd_head o_head
);

    ufd_pkg::t_ufd_rec r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt,  n_cnt;
    logic       do_pop;

    assign o_full      = (r_cnt == 2'd2);
    assign o_head.avail = (r_cnt != 2'd0);
    assign o_head.rec   = r_mem[r_rptr];
    assign do_pop       = i_pop && o_head.avail;

    always_comb begin
        n_wptr = r_wptr ^ i_push.push;
        n_rptr = r_rptr ^ do_pop;
        n_cnt  = r_cnt + 2'(i_push.push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wptr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

/* rtl/ufd_back.sv */
// Back end: takes queued transactions, resolves the CRC verdict and holds the
// result in the output register. Depends on ufd_pkg and ufd_out_if.
module ufd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ufd_pkg::t_ufd_head i_head,
    output logic               o_pop,
    ufd_out_if.source          o_res
);

    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_data;
    logic [7:0] r_index;
    logic       r_ver;
    logic [7:0] r_cmd;
    logic [7:0] r_len;
    logic       r_checked;
    logic       r_ok;
    logic       is_end;

    assign o_pop  = i_head.avail && (!r_valid || o_res.ready);
    assign is_end = (i_head.rec.kind == ufd_pkg::KIND_FRAME_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind    <= i_head.rec.kind;
            r_data    <= i_head.rec.data;
            r_index   <= i_head.rec.index;
            r_ver     <= i_head.rec.version;
            r_cmd     <= i_head.rec.command;
            r_len     <= i_head.rec.length;
            r_checked <= is_end && i_head.rec.version;
            r_ok      <= is_end && i_head.rec.version && i_head.rec.fits
                         && (i_head.rec.crc_calc == i_head.rec.crc_rcvd);
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.result_kind   = r_kind;
    assign o_res.payload_byte  = r_data;
    assign o_res.payload_index = r_index;
    assign o_res.frame_version = r_ver;
    assign o_res.frame_command = r_cmd;
    assign o_res.frame_length  = r_len;
    assign o_res.crc_checked   = r_checked;
    assign o_res.crc_ok        = r_ok;

endmodule

/* rtl/uart_frame_deframer_crc_check_unit.sv */
// A result is registered in the queue and then in the output register after the byte that caused it is accepted.
// Throughput: one byte per cycle while the queue has room; header, drop and closing bytes are consumed too.
// The CRC update is one byte per cycle in the front end while the queue has room; a two-entry queue decouples
// it from the output register. Synchronous active-low reset returns to header hunt,
// empties the queue and sets max_payload_length to 64.
module uart_frame_deframer_crc_check_unit #(
    parameter int CRC_SPAN = 38
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    ufd_in_if.sink     i_rx,
    ufd_out_if.source  o_res
);

    ufd_pkg::t_ufd_push w_push;
    ufd_pkg::t_ufd_head w_head;
    logic               w_full;
    logic               w_pop;

    ufd_front #(
        .CRC_SPAN (CRC_SPAN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (i_rx),
        .i_full      (w_full),
        .o_push      (w_push)
    );

    ufd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    ufd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |-> !w_full)
        else $error("push into full queue");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

    a_payload_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.result_kind == ufd_pkg::KIND_PAYLOAD)
        |-> (!o_res.crc_checked && !o_res.crc_ok
             && o_res.payload_index < o_res.frame_length))
        else $error("bad payload result");

    a_ok_needs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.crc_ok) |-> (o_res.crc_checked && o_res.frame_version))
        else $error("crc_ok without version-1 check");

endmodule
